>>> rtl/core/uabf_pkg.sv
`timescale 1ns / 1ps

package uabf_pkg;

   localparam int RING_DEPTH = 32;
   localparam int PTR_W = $clog2(RING_DEPTH);

   localparam logic [1:0] CMD_FRAME_RX  = 2'd0;
   localparam logic [1:0] CMD_HOST_READ = 2'd1;
   localparam logic [1:0] CMD_HOST_SEND = 2'd2;
   localparam logic [1:0] CMD_TX_READY  = 2'd3;

   localparam int ERR_FRAME_BIT    = 0;
   localparam int ERR_OVERRUN_BIT  = 1;
   localparam int ERR_PARITY_BIT   = 2;
   localparam int ERR_OVERFLOW_BIT = 3;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       line_frame_error;
      logic       line_overrun;
      logic       line_parity_error;
   } req_type;

   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_byte;
      logic       err_frame;
      logic       err_overrun;
      logic       err_parity;
      logic       err_ring_overflow;
      logic       send_accepted;
      logic       line_out_valid;
      logic [7:0] line_out_byte;
      logic       transmit_active;
   } rsp_type;

   typedef struct packed {
      logic       wr_en;
      ptr_type    wr_addr;
      logic [7:0] wr_data;
      logic       rd_en;
      ptr_type    rd_addr;
   } ram_op_type;

   typedef struct packed {
      logic       read_valid;
      logic [3:0] errors;
      logic       send_accepted;
      logic       line_out_valid;
      logic       transmit_active;
   } info_type;

endpackage

>>> rtl/core/uart_buffered_fifo_pair.sv
`timescale 1ns / 1ps

// Receive and transmit byte rings for a serial port, each holding up to
// RING_DEPTH-1 bytes in a one-port-read, one-port-write memory.
// The req_ channel carries one command word: a received frame, a host read,
// a host send or a transmitter-ready event. Every command returns exactly
// one word on the rsp_ channel, in order.
// A command is accepted when req_valid and req_ready are both high; its
// response is valid in the next cycle, read straight from the ring memory's
// output register. A new command is taken every cycle while the response side
// keeps up, so the sustained rate is one word per cycle; each command makes
// at most one memory access.
// If the receiver stalls, the pending response holds and req_ready drops
// until it is taken; a response being taken frees the slot in that cycle.
// Reset empties both rings, clears the sticky error flags and the transmit
// active flag, and drops any pending response. No clearing pass is needed.
module uart_buffered_fifo_pair (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  uabf_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output uabf_pkg::rsp_type rsp_word
);

   logic                 accept;
   logic                 rsp_valid_ff, rsp_valid_in;
   uabf_pkg::ram_op_type rx_op, tx_op;
   uabf_pkg::info_type   info;
   logic [7:0]           rx_rd_data, tx_rd_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   uabf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_word),
      .rx_op  (rx_op),
      .tx_op  (tx_op),
      .info   (info)
   );

   uabf_ring_ram u_rx_ram (
      .clock   (clock),
      .op      (rx_op),
      .rd_data (rx_rd_data)
   );

   uabf_ring_ram u_tx_ram (
      .clock   (clock),
      .op      (tx_op),
      .rd_data (tx_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_word                   = '0;
      rsp_word.read_valid        = info.read_valid;
      rsp_word.read_byte         = info.read_valid ? rx_rd_data : 8'd0;
      rsp_word.err_frame         = info.errors[uabf_pkg::ERR_FRAME_BIT];
      rsp_word.err_overrun       = info.errors[uabf_pkg::ERR_OVERRUN_BIT];
      rsp_word.err_parity        = info.errors[uabf_pkg::ERR_PARITY_BIT];
      rsp_word.err_ring_overflow = info.errors[uabf_pkg::ERR_OVERFLOW_BIT];
      rsp_word.send_accepted     = info.send_accepted;
      rsp_word.line_out_valid    = info.line_out_valid;
      rsp_word.line_out_byte     = info.line_out_valid ? tx_rd_data : 8'd0;
      rsp_word.transmit_active   = info.transmit_active;
   end

   a_one_action : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_word.read_valid, rsp_word.send_accepted,
                                rsp_word.line_out_valid}) <= 1)
      else $error("more than one ring action in a response");

   a_send_activates : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.send_accepted |-> rsp_word.transmit_active)
      else $error("accepted send left transmitter inactive");

   a_pop_while_active : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.line_out_valid |-> rsp_word.transmit_active)
      else $error("byte handed out while transmitter inactive");

   a_accept_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted command produced no response");

endmodule

>>> rtl/core/uabf_ring_ram.sv
`timescale 1ns / 1ps

module uabf_ring_ram (
   input  logic                 clock,
   input  uabf_pkg::ram_op_type op,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [uabf_pkg::RING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (op.wr_en) begin
         mem[op.wr_addr] <= op.wr_data;
      end
      if (op.rd_en) begin
         rd_data_ff <= mem[op.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/uabf_ctrl.sv
`timescale 1ns / 1ps

module uabf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  uabf_pkg::req_type    req,
   output uabf_pkg::ram_op_type rx_op,
   output uabf_pkg::ram_op_type tx_op,
   output uabf_pkg::info_type   info
);

   uabf_pkg::ptr_type  rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   uabf_pkg::ptr_type  tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   uabf_pkg::ptr_type  rx_wp_next, rx_rp_next, tx_wp_next, tx_rp_next;
   logic [3:0]         sticky_ff, sticky_in;
   logic               tx_en_ff, tx_en_in;
   uabf_pkg::info_type info_ff, info_in;
   logic [3:0]         line_errors;

   assign rx_wp_next = rx_wp_ff + uabf_pkg::PTR_W'(1);
   assign rx_rp_next = rx_rp_ff + uabf_pkg::PTR_W'(1);
   assign tx_wp_next = tx_wp_ff + uabf_pkg::PTR_W'(1);
   assign tx_rp_next = tx_rp_ff + uabf_pkg::PTR_W'(1);

   always_comb begin
      line_errors = '0;
      line_errors[uabf_pkg::ERR_FRAME_BIT]   = req.line_frame_error;
      line_errors[uabf_pkg::ERR_OVERRUN_BIT] = req.line_overrun;
      line_errors[uabf_pkg::ERR_PARITY_BIT]  = req.line_parity_error;
   end

   always_comb begin
      rx_wp_in  = rx_wp_ff;
      rx_rp_in  = rx_rp_ff;
      tx_wp_in  = tx_wp_ff;
      tx_rp_in  = tx_rp_ff;
      sticky_in = sticky_ff;
      tx_en_in  = tx_en_ff;
      info_in   = '0;
      rx_op     = '0;
      tx_op     = '0;
      rx_op.wr_addr = rx_wp_next;
      rx_op.wr_data = req.data_byte;
      rx_op.rd_addr = rx_rp_next;
      tx_op.wr_addr = tx_wp_next;
      tx_op.wr_data = req.data_byte;
      tx_op.rd_addr = tx_rp_next;
      if (accept) begin
         case (req.command)
            uabf_pkg::CMD_FRAME_RX: begin
               if (rx_wp_next == rx_rp_ff) begin
                  sticky_in[uabf_pkg::ERR_OVERFLOW_BIT] = 1'b1;
               end else begin
                  rx_op.wr_en = 1'b1;
                  rx_wp_in    = rx_wp_next;
                  sticky_in   = sticky_ff | line_errors;
               end
            end
            uabf_pkg::CMD_HOST_READ: begin
               if (rx_wp_ff != rx_rp_ff) begin
                  rx_op.rd_en        = 1'b1;
                  rx_rp_in           = rx_rp_next;
                  info_in.read_valid = 1'b1;
                  info_in.errors     = sticky_ff;
                  sticky_in          = '0;
               end
            end
            uabf_pkg::CMD_HOST_SEND: begin
               if (tx_wp_next != tx_rp_ff) begin
                  tx_op.wr_en           = 1'b1;
                  tx_wp_in              = tx_wp_next;
                  tx_en_in              = 1'b1;
                  info_in.send_accepted = 1'b1;
               end
            end
            uabf_pkg::CMD_TX_READY: begin
               if (tx_wp_ff != tx_rp_ff) begin
                  tx_op.rd_en            = 1'b1;
                  tx_rp_in               = tx_rp_next;
                  info_in.line_out_valid = 1'b1;
               end else begin
                  tx_en_in = 1'b0;
               end
            end
            default: begin
               tx_en_in = tx_en_ff;
            end
         endcase
      end
      info_in.transmit_active = tx_en_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wp_ff  <= '0;
         rx_rp_ff  <= '0;
         tx_wp_ff  <= '0;
         tx_rp_ff  <= '0;
         sticky_ff <= '0;
         tx_en_ff  <= 1'b0;
      end else begin
         rx_wp_ff  <= rx_wp_in;
         rx_rp_ff  <= rx_rp_in;
         tx_wp_ff  <= tx_wp_in;
         tx_rp_ff  <= tx_rp_in;
         sticky_ff <= sticky_in;
         tx_en_ff  <= tx_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= info_in;
      end
   end

   assign info = info_ff;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned RANDOM_WORDS = 1900;
   localparam int unsigned HOLD_CYCLES = 100;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   uabf_pkg::req_type req_word = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   uabf_pkg::rsp_type rsp_word;

   uart_buffered_fifo_pair u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Software copy of both rings, the sticky flags and the transmit-active flag.
   logic [7:0]        rx_ring [uabf_pkg::RING_DEPTH];
   logic [7:0]        tx_ring [uabf_pkg::RING_DEPTH];
   uabf_pkg::ptr_type rx_head = '0;
   uabf_pkg::ptr_type rx_tail = '0;
   uabf_pkg::ptr_type tx_head = '0;
   uabf_pkg::ptr_type tx_tail = '0;
   logic [3:0]        sticky_flags = '0;
   logic              tx_busy = 1'b0;

   uabf_pkg::req_type pending_words[$];
   uabf_pkg::rsp_type expected_rsps[$];
   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   bit          req_fired = 1'b0;
   bit          rsp_fired = 1'b0;
   int unsigned req_gap = 0;
   int unsigned req_calm = 0;
   int unsigned rsp_gap = 0;
   int unsigned rsp_calm = 0;
   int unsigned hold_left = 0;
   int unsigned next_hold_at = 400;

   function automatic uabf_pkg::rsp_type ring_step(input uabf_pkg::req_type w);
      uabf_pkg::rsp_type r;
      uabf_pkg::ptr_type nxt;
      logic [3:0]        err;
      r = '0;
      case (w.command)
         uabf_pkg::CMD_FRAME_RX: begin
            err = '0;
            err[uabf_pkg::ERR_FRAME_BIT] = w.line_frame_error;
            err[uabf_pkg::ERR_OVERRUN_BIT] = w.line_overrun;
            err[uabf_pkg::ERR_PARITY_BIT] = w.line_parity_error;
            nxt = rx_head + 1'b1;
            if (nxt == rx_tail) begin
               err = '0;
               err[uabf_pkg::ERR_OVERFLOW_BIT] = 1'b1;
            end else begin
               rx_head = nxt;
               rx_ring[nxt] = w.data_byte;
            end
            sticky_flags = sticky_flags | err;
         end
         uabf_pkg::CMD_HOST_READ: begin
            if (rx_head != rx_tail) begin
               rx_tail = rx_tail + 1'b1;
               r.read_valid = 1'b1;
               r.read_byte = rx_ring[rx_tail];
               r.err_frame = sticky_flags[uabf_pkg::ERR_FRAME_BIT];
               r.err_overrun = sticky_flags[uabf_pkg::ERR_OVERRUN_BIT];
               r.err_parity = sticky_flags[uabf_pkg::ERR_PARITY_BIT];
               r.err_ring_overflow = sticky_flags[uabf_pkg::ERR_OVERFLOW_BIT];
               sticky_flags = '0;
            end
         end
         uabf_pkg::CMD_HOST_SEND: begin
            nxt = tx_head + 1'b1;
            if (nxt != tx_tail) begin
               tx_ring[nxt] = w.data_byte;
               tx_head = nxt;
               tx_busy = 1'b1;
               r.send_accepted = 1'b1;
            end
         end
         uabf_pkg::CMD_TX_READY: begin
            if (tx_head != tx_tail) begin
               tx_tail = tx_tail + 1'b1;
               r.line_out_valid = 1'b1;
               r.line_out_byte = tx_ring[tx_tail];
            end else begin
               tx_busy = 1'b0;
            end
         end
         default: begin
            tx_busy = tx_busy;
         end
      endcase
      r.transmit_active = tx_busy;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t: mismatch on %s, got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_word(input uabf_pkg::rsp_type got, input uabf_pkg::rsp_type want);
      if (got.read_valid !== want.read_valid)
         report_mismatch("read_valid", 8'(got.read_valid), 8'(want.read_valid));
      if (got.read_byte !== want.read_byte)
         report_mismatch("read_byte", got.read_byte, want.read_byte);
      if (got.err_frame !== want.err_frame)
         report_mismatch("err_frame", 8'(got.err_frame), 8'(want.err_frame));
      if (got.err_overrun !== want.err_overrun)
         report_mismatch("err_overrun", 8'(got.err_overrun), 8'(want.err_overrun));
      if (got.err_parity !== want.err_parity)
         report_mismatch("err_parity", 8'(got.err_parity), 8'(want.err_parity));
      if (got.err_ring_overflow !== want.err_ring_overflow)
         report_mismatch("err_ring_overflow", 8'(got.err_ring_overflow),
                         8'(want.err_ring_overflow));
      if (got.send_accepted !== want.send_accepted)
         report_mismatch("send_accepted", 8'(got.send_accepted),
                         8'(want.send_accepted));
      if (got.line_out_valid !== want.line_out_valid)
         report_mismatch("line_out_valid", 8'(got.line_out_valid),
                         8'(want.line_out_valid));
      if (got.line_out_byte !== want.line_out_byte)
         report_mismatch("line_out_byte", got.line_out_byte, want.line_out_byte);
      if (got.transmit_active !== want.transmit_active)
         report_mismatch("transmit_active", 8'(got.transmit_active),
                         8'(want.transmit_active));
   endtask

   // Mostly back-to-back, some short gaps, a few long ones, and calm stretches.
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(40, 150);
         return 0;
      end
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic uabf_pkg::req_type make_word(input logic [1:0] cmd,
                                                   input logic [7:0] data,
                                                   input logic fe, input logic ov,
                                                   input logic pe);
      uabf_pkg::req_type w;
      w.command = cmd;
      w.data_byte = data;
      w.line_frame_error = fe;
      w.line_overrun = ov;
      w.line_parity_error = pe;
      return w;
   endfunction

   function automatic uabf_pkg::req_type random_word(input logic [1:0] cmd,
                                                     input int unsigned err_pct);
      return make_word(cmd, 8'($urandom_range(0, 255)),
                       $urandom_range(0, 99) < err_pct,
                       $urandom_range(0, 99) < err_pct,
                       $urandom_range(0, 99) < err_pct);
   endfunction

   task automatic queue_word(input uabf_pkg::req_type w);
      pending_words.push_back(w);
      words_queued++;
   endtask

   always @(posedge clock) begin
      req_fired = !reset && req_valid && req_ready;
      rsp_fired = !reset && rsp_valid && rsp_ready;
      if (rsp_fired) begin
         if (expected_rsps.size() == 0)
            report_mismatch("unexpected response word", rsp_word.read_byte, 8'h00);
         else
            check_word(rsp_word, expected_rsps.pop_front());
      end
      if (req_fired) begin
         expected_rsps.push_back(ring_step(req_word));
         words_taken++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (pending_words.size() != 0) begin
         req_word <= pending_words.pop_front();
         req_valid <= 1'b1;
         req_gap = pick_gap(req_calm);
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (words_taken >= next_hold_at) begin
         rsp_ready <= 1'b0;
         hold_left = HOLD_CYCLES;
         next_hold_at += 800;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_fired) rsp_gap = pick_gap(rsp_calm);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int unsigned random_start;
      int unsigned seg;
      int unsigned n;
      int unsigned m;

      queue_word(make_word(uabf_pkg::CMD_TX_READY, 8'hFF, 1'b1, 1'b1, 1'b1));
      queue_word(make_word(uabf_pkg::CMD_HOST_READ, 8'hFF, 1'b1, 1'b1, 1'b1));
      queue_word(make_word(uabf_pkg::CMD_FRAME_RX, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_FRAME_RX, 8'hFF, 1'b1, 1'b1, 1'b1));
      queue_word(make_word(uabf_pkg::CMD_FRAME_RX, 8'h5A, 1'b1, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_FRAME_RX, 8'hA5, 1'b0, 1'b1, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_FRAME_RX, 8'h3C, 1'b0, 1'b0, 1'b1));
      queue_word(make_word(uabf_pkg::CMD_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_HOST_SEND, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_HOST_SEND, 8'hFF, 1'b1, 1'b1, 1'b1));
      queue_word(make_word(uabf_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));
      queue_word(make_word(uabf_pkg::CMD_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0));

      // Floods can push a ring past full and drain it past empty; the rest is mixed traffic.
      random_start = words_queued;
      while (words_queued - random_start < RANDOM_WORDS) begin
         seg = $urandom_range(0, 9);
         if (seg < 2) begin
            n = $urandom_range(26, 40);
            m = $urandom_range(n - 4, n + 3);
            repeat (n) queue_word(random_word(uabf_pkg::CMD_FRAME_RX, 15));
            repeat (m) queue_word(random_word(uabf_pkg::CMD_HOST_READ, 50));
         end else if (seg < 4) begin
            n = $urandom_range(26, 40);
            m = $urandom_range(n - 4, n + 3);
            repeat (n) queue_word(random_word(uabf_pkg::CMD_HOST_SEND, 50));
            repeat (m) queue_word(random_word(uabf_pkg::CMD_TX_READY, 50));
         end else if (seg < 8) begin
            repeat ($urandom_range(20, 60))
               queue_word(random_word(2'($urandom_range(0, 3)), 10));
         end else begin
            repeat ($urandom_range(10, 30))
               queue_word(random_word(2'($urandom_range(0, 3)), 50));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_taken != words_queued || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
